// ----- rtl/multitouch_slot_tracker_core_macros.svh -----
// Assertion macros used by the slot tracker RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef MULTITOUCH_SLOT_TRACKER_CORE_MACROS_SVH
`define MULTITOUCH_SLOT_TRACKER_CORE_MACROS_SVH

// Check that cons holds in every cycle where ante holds.
`define MST_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("slot tracker check failed");

// Check that cond never holds.
`define MST_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("slot tracker check failed");

`endif

// ----- rtl/mst_pkg.sv -----
// Types and constants of the multi-touch slot tracker.
// Depends on nothing; used by the top level, mst_front and mst_back.
package mst_pkg;

	localparam int SLOT_W = 4;
	localparam int VAL_W  = 32;
	localparam int FLAG_W = 5;

	localparam logic [15:0] EVT_ABS   = 16'd3;
	localparam logic [15:0] CODE_SLOT = 16'h002F;
	localparam logic [15:0] CODE_X    = 16'h0035;
	localparam logic [15:0] CODE_Y    = 16'h0036;
	localparam logic [15:0] CODE_ID   = 16'h0039;

	localparam logic [FLAG_W-1:0] FLAG_ID  = 5'h01;
	localparam logic [FLAG_W-1:0] FLAG_X   = 5'h02;
	localparam logic [FLAG_W-1:0] FLAG_Y   = 5'h04;
	localparam logic [FLAG_W-1:0] FLAG_REP = 5'h08;
	localparam logic [FLAG_W-1:0] FLAG_CHG = 5'h10;

	localparam logic [FLAG_W-1:0] FLAGS_NEW      = 5'h17;
	localparam logic [FLAG_W-1:0] FLAGS_UPDATED  = 5'h1F;
	localparam logic [FLAG_W-1:0] FLAGS_REPORTED = 5'h0F;
	localparam logic [FLAG_W-1:0] FLAGS_NONE     = 5'h00;

	localparam logic [VAL_W-1:0] ID_LIFTED = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_CHECK = 2'd0,
		OP_X     = 2'd1,
		OP_Y     = 2'd2,
		OP_ID    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_TOUCH   = 2'd0,
		KIND_MOVE    = 2'd1,
		KIND_RELEASE = 2'd2
	} kind_t;

	typedef struct packed {
		logic              screen;
		logic [SLOT_W-1:0] slot;
		op_t               op;
		logic [VAL_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		kind_t             kind;
		logic              screen;
		logic [SLOT_W-1:0] slot;
		logic [VAL_W-1:0]  x;
		logic [VAL_W-1:0]  y;
	} res_t;

endpackage

// ----- rtl/multitouch_slot_tracker_core.sv -----
// Multi-touch slot tracker, top level. Accepts one event per clock while
// full is low and returns at most one touch, move or release report per
// event. Sustained rate: one event per cycle while no queue stalls; the
// contact store does one read-modify-write a cycle, and that single port
// sets the rate. An accepted event is registered in the command queue;
// the back part decides its report from the queue head and registers it
// in the result queue, which drives the result ports. The back part
// stalls while the result queue is full; full rises once the command
// queue holds two commands. Events of a screen not below SCREENS give
// no report. Depends on mst_pkg, mst_fifo, mst_front and mst_back.
module multitouch_slot_tracker_core #(
	parameter int SLOTS   = 10,
	parameter int SCREENS = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	// request side
	input  logic               push,
	output logic               full,
	input  logic               screen,
	input  logic [15:0]        ev_type,
	input  logic [15:0]        ev_code,
	input  logic signed [31:0] ev_value,
	// result side
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         kind,
	output logic               out_screen,
	output logic [3:0]         out_slot,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y
);

	localparam int CMD_W = $bits(mst_pkg::cmd_t);
	localparam int RES_W = $bits(mst_pkg::res_t);

	mst_pkg::cmd_t    cmd_in;
	mst_pkg::cmd_t    cmd_out;
	logic [CMD_W-1:0] cmd_rdata;
	logic             cmd_push;
	logic             cmd_full;
	logic             cmd_pop;
	logic             cmd_empty;
	mst_pkg::res_t    res_in;
	mst_pkg::res_t    res_out;
	logic [RES_W-1:0] res_rdata;
	logic             res_push;
	logic             res_full;

	// Front: classify each request and track the current slot per screen.
	mst_front #(
		.SLOTS   (SLOTS),
		.SCREENS (SCREENS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.screen   (screen),
		.ev_type  (ev_type),
		.ev_code  (ev_code),
		.ev_value ($unsigned(ev_value)),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	// Hold classified commands so front and back stall on their own.
	mst_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	assign cmd_out = mst_pkg::cmd_t'(cmd_rdata);

	// Back: update the contact entry and decide the report.
	mst_back #(
		.SLOTS   (SLOTS),
		.SCREENS (SCREENS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	// Hold finished reports until the consumer pops them.
	mst_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_out    = mst_pkg::res_t'(res_rdata);
	assign kind       = res_out.kind;
	assign out_screen = res_out.screen;
	assign out_slot   = res_out.slot;
	assign pos_x      = $signed(res_out.x);
	assign pos_y      = $signed(res_out.y);

endmodule

// ----- rtl/mst_fifo.sv -----
// Small first-in first-out queue of flip-flops.
// Depends on nothing; used between the tracker parts and on the result side.
module mst_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/mst_front.sv -----
// Front part of the slot tracker: accept events, keep the current slot
// of each screen and turn each event into a slot command. Depends on mst_pkg.
module mst_front #(
	parameter int SLOTS   = 10,
	parameter int SCREENS = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               screen,
	input  logic [15:0]        ev_type,
	input  logic [15:0]        ev_code,
	input  logic [31:0]        ev_value,
	output logic               cmd_push,
	output mst_pkg::cmd_t      cmd,
	input  logic               cmd_full
);

	// Only screens 0 and 1 can be addressed through the one-bit port.
	localparam int NSCR = (SCREENS < 2) ? SCREENS : 2;

	logic [mst_pkg::SLOT_W-1:0] cur_slot_q [NSCR];
	logic [mst_pkg::SLOT_W-1:0] cur_slot;
	logic                       accept;
	logic                       scr_ok;
	logic                       is_abs;
	logic                       slot_ok;
	logic                       slot_sel;

	assign full    = cmd_full;
	assign accept  = push && !cmd_full;
	assign scr_ok  = (32'(screen) < SCREENS);
	assign is_abs  = (ev_type == mst_pkg::EVT_ABS);
	assign slot_ok = (ev_value < 32'(SLOTS));
	assign slot_sel = is_abs && (ev_code == mst_pkg::CODE_SLOT) && slot_ok;

	always_comb begin
		if (NSCR == 1) begin
			cur_slot = cur_slot_q[0];
		end else begin
			cur_slot = cur_slot_q[screen];
		end
	end

	always_comb begin
		cmd.screen = screen;
		cmd.value  = ev_value;
		cmd.slot   = slot_sel ? ev_value[mst_pkg::SLOT_W-1:0] : cur_slot;
		cmd.op     = mst_pkg::OP_CHECK;
		if (is_abs) begin
			case (ev_code)
				mst_pkg::CODE_X:  cmd.op = mst_pkg::OP_X;
				mst_pkg::CODE_Y:  cmd.op = mst_pkg::OP_Y;
				mst_pkg::CODE_ID: cmd.op = mst_pkg::OP_ID;
				default:          cmd.op = mst_pkg::OP_CHECK;
			endcase
		end
	end

	// Drop events of screens that do not exist.
	assign cmd_push = accept && scr_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSCR; i++) begin
				cur_slot_q[i] <= '0;
			end
		end else if (cmd_push && slot_sel) begin
			if (NSCR == 1) begin
				cur_slot_q[0] <= ev_value[mst_pkg::SLOT_W-1:0];
			end else begin
				cur_slot_q[screen] <= ev_value[mst_pkg::SLOT_W-1:0];
			end
		end
	end

endmodule

// ----- rtl/mst_back.sv -----
// Back part of the slot tracker: read-modify-write of one contact entry per
// command and the touch, move and release decision. Depends on mst_pkg and
// the assertion macros.
`include "multitouch_slot_tracker_core_macros.svh"

module mst_back #(
	parameter int SLOTS   = 10,
	parameter int SCREENS = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	input  mst_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          res_push,
	output mst_pkg::res_t res,
	input  logic          res_full
);

	localparam int NSCR = (SCREENS < 2) ? SCREENS : 2;
	localparam int NENT = NSCR * SLOTS;
	localparam int EW   = (NENT > 1) ? $clog2(NENT) : 1;

	logic [mst_pkg::VAL_W-1:0]  id_q    [NENT];
	logic [mst_pkg::VAL_W-1:0]  x_q     [NENT];
	logic [mst_pkg::VAL_W-1:0]  y_q     [NENT];
	logic [mst_pkg::FLAG_W-1:0] flags_q [NENT];
	logic [NENT-1:0]            vld_q;

	logic [5:0]                 idx_wide;
	logic [EW-1:0]              idx;
	logic                       go;
	logic [mst_pkg::VAL_W-1:0]  rd_id;
	logic [mst_pkg::VAL_W-1:0]  rd_x;
	logic [mst_pkg::VAL_W-1:0]  rd_y;
	logic [mst_pkg::FLAG_W-1:0] rd_flags;
	logic [mst_pkg::VAL_W-1:0]  nid;
	logic [mst_pkg::VAL_W-1:0]  nx;
	logic [mst_pkg::VAL_W-1:0]  ny;
	logic [mst_pkg::FLAG_W-1:0] nflags;
	logic [mst_pkg::FLAG_W-1:0] wr_flags;
	logic                       hit;
	mst_pkg::kind_t             kind;

	assign go       = !cmd_empty && !res_full;
	assign cmd_pop  = go;
	assign idx_wide = (cmd.screen ? 6'(SLOTS) : 6'd0) + 6'(cmd.slot);
	assign idx      = idx_wide[EW-1:0];

	// An entry never written since reset reads as zero.
	assign rd_id    = vld_q[idx] ? id_q[idx] : '0;
	assign rd_x     = vld_q[idx] ? x_q[idx] : '0;
	assign rd_y     = vld_q[idx] ? y_q[idx] : '0;
	assign rd_flags = flags_q[idx];

	always_comb begin
		nid    = rd_id;
		nx     = rd_x;
		ny     = rd_y;
		nflags = rd_flags;
		case (cmd.op)
			mst_pkg::OP_X: begin
				nx     = cmd.value;
				nflags = rd_flags | mst_pkg::FLAG_X
					| ((rd_x != cmd.value) ? mst_pkg::FLAG_CHG : mst_pkg::FLAGS_NONE);
			end
			mst_pkg::OP_Y: begin
				ny     = cmd.value;
				nflags = rd_flags | mst_pkg::FLAG_Y
					| ((rd_y != cmd.value) ? mst_pkg::FLAG_CHG : mst_pkg::FLAGS_NONE);
			end
			mst_pkg::OP_ID: begin
				nid    = cmd.value;
				nflags = rd_flags | mst_pkg::FLAG_ID | mst_pkg::FLAG_CHG;
			end
			default: begin
				nflags = rd_flags;
			end
		endcase
	end

	always_comb begin
		hit      = 1'b0;
		kind     = mst_pkg::KIND_TOUCH;
		wr_flags = nflags;
		if (nflags == mst_pkg::FLAGS_NEW) begin
			hit      = 1'b1;
			wr_flags = mst_pkg::FLAGS_REPORTED;
		end else if (nflags == mst_pkg::FLAGS_UPDATED) begin
			hit = 1'b1;
			if (nid == mst_pkg::ID_LIFTED) begin
				kind     = mst_pkg::KIND_RELEASE;
				wr_flags = mst_pkg::FLAGS_NONE;
			end else begin
				kind     = mst_pkg::KIND_MOVE;
				wr_flags = nflags & ~mst_pkg::FLAG_CHG;
			end
		end
	end

	assign res_push   = go && hit;
	assign res.kind   = kind;
	assign res.screen = cmd.screen;
	assign res.slot   = cmd.slot;
	assign res.x      = nx;
	assign res.y      = ny;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			for (int i = 0; i < NENT; i++) begin
				flags_q[i] <= mst_pkg::FLAGS_NONE;
			end
		end else if (go) begin
			vld_q[idx]   <= 1'b1;
			flags_q[idx] <= wr_flags;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			id_q[idx] <= nid;
			x_q[idx]  <= nx;
			y_q[idx]  <= ny;
		end
	end

	`MST_ASSERT_IMPLY(a_flags_settled, clk, arst_n, go, (wr_flags != mst_pkg::FLAGS_NEW) && (wr_flags != mst_pkg::FLAGS_UPDATED))
	`MST_ASSERT_NEVER(a_no_push_full, clk, arst_n, res_push && res_full)
	`MST_ASSERT_IMPLY(a_release_id, clk, arst_n, res_push && (kind == mst_pkg::KIND_RELEASE), (nid == mst_pkg::ID_LIFTED) && (wr_flags == mst_pkg::FLAGS_NONE))

endmodule
